>>> hw/rtl/bloom_filter_double_hash_assert.svh
// ----------------------------------------------------------------------------
// Bloom filter assertion macros
// Shorthand for the concurrent checks of the Bloom filter, clocked on clk_i
// and held off while rst_ni is low. They vanish in synthesis.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_DOUBLE_HASH_ASSERT_SVH
`define BLOOM_FILTER_DOUBLE_HASH_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define BFDH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bloom filter check failed");
// Next-cycle implication.
`define BFDH_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bloom filter check failed");
`else
`define BFDH_ASSERT_IMP(label, ante, cons)
`define BFDH_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/bfdh_pkg.sv
// ----------------------------------------------------------------------------
// Bloom filter package
// Table geometry, field widths, operation codes and the control structs
// shared by the Bloom filter modules.
// ----------------------------------------------------------------------------
package bfdh_pkg;

  // Table geometry: both sizes are powers of two.
  localparam int unsigned TABLE_BITS  = 65536;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned TABLE_WORDS = TABLE_BITS / WORD_BITS;
  localparam int unsigned IDX_W       = $clog2(TABLE_BITS);
  localparam int unsigned BIT_W       = $clog2(WORD_BITS);
  localparam int unsigned ADDR_W      = IDX_W - BIT_W;

  // Field widths.
  localparam int unsigned HASH_W = 32;
  localparam int unsigned CNT_W  = 5;

  localparam logic [CNT_W-1:0] PROBE_COUNT_RESET = CNT_W'(7);

  // Operation codes carried by the func field.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // Sequencer commands to the probe generator.
  typedef struct packed {
    logic load;
    logic step;
  } probe_ctrl_t;

  // Probe generator status back to the sequencer.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             none_left;
  } probe_stat_t;

endpackage

>>> hw/rtl/bfdh_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module bfdh_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/bfdh_probe_gen.sv
// ----------------------------------------------------------------------------
// Bloom filter probe generator
// Holds the running bit index and the probes left for one item, and steps
// the index by the stride with one shared adder.
// ----------------------------------------------------------------------------
module bfdh_probe_gen
  import bfdh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  probe_ctrl_t       ctrl_i,
  input  logic [HASH_W-1:0] first_hash_i,
  input  logic [HASH_W-1:0] second_hash_i,
  input  logic [CNT_W-1:0]  probe_count_i,
  output probe_stat_t       stat_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] stride_q, stride_d;
  logic [CNT_W-1:0] left_q, left_d;

  // Only the low index bits of the hashes matter, as the table size is a
  // power of two and the sum wraps.
  always_comb begin
    idx_d    = idx_q;
    stride_d = stride_q;
    left_d   = left_q;
    if (ctrl_i.load) begin
      idx_d    = first_hash_i[IDX_W-1:0];
      stride_d = second_hash_i[IDX_W-1:0];
      left_d   = probe_count_i;
    end else if (ctrl_i.step) begin
      idx_d  = idx_q + stride_q;
      left_d = left_q - CNT_W'(1);
    end
  end

  // The count of probes left is control state; the index and stride are
  // payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else begin
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    stride_q <= stride_d;
  end

  assign stat_o.idx       = idx_q;
  assign stat_o.none_left = (left_q == '0);

endmodule

>>> hw/rtl/bloom_filter_double_hash.sv
// An item's result follows its probes: a table read and a compare or write
// per probe, fewer for a query that meets a clear bit early; the result is
// held while stalled. The block takes no new item until the last result
// has been taken. After reset it clears its 1024-word table, one word a
// cycle, and takes no item until the sweep ends; probe_count resets to 7.
// ----------------------------------------------------------------------------
// Bloom filter with double hashing
// Sequencer over a word-organised bit table: each item makes up to probe_count
// probes at first_hash + i * second_hash, setting bits for an insert and
// testing them for a query.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash
  import bfdh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port.
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  // Input item channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic [HASH_W-1:0] first_hash_i,
  input  logic [HASH_W-1:0] second_hash_i,
  // Result item channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              present_o
);

`include "bloom_filter_double_hash_assert.svh"

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_RESP
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic                func_q, func_d;
  logic                present_q, present_d;
  logic [CNT_W-1:0]    probe_count_q;

  probe_ctrl_t         probe_ctrl;
  probe_stat_t         probe_stat;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [BIT_W-1:0]    bit_sel;
  logic                in_accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign bit_sel    = probe_stat.idx[BIT_W-1:0];

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_count_q <= PROBE_COUNT_RESET;
    end else if (cfg_we_i) begin
      probe_count_q <= cfg_wdata_i;
    end
  end

  // Index generation for the current item.
  bfdh_probe_gen u_probe_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (probe_ctrl),
    .first_hash_i (first_hash_i),
    .second_hash_i(second_hash_i),
    .probe_count_i(probe_count_q),
    .stat_o       (probe_stat)
  );

  // Bit table storage.
  bfdh_ram #(
    .Width(WORD_BITS),
    .Depth(TABLE_WORDS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(probe_stat.idx[IDX_W-1:BIT_W]),
    .rdata_o(ram_rdata)
  );

  // Sequencer: clearing sweep, then a read and a check or write per probe.
  always_comb begin
    state_d         = state_q;
    clr_d           = clr_q;
    func_d          = func_q;
    present_d       = present_q;
    probe_ctrl.load = 1'b0;
    probe_ctrl.step = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = probe_stat.idx[IDX_W-1:BIT_W];
    ram_wdata       = ram_rdata | (WORD_BITS'(1) << bit_sel);
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(TABLE_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          probe_ctrl.load = 1'b1;
          func_d          = func_i;
          // A query is present until a clear bit is found.
          present_d       = (func_i == FUNC_QUERY);
          state_d         = ST_READ;
        end
      end
      ST_READ: begin
        // The word address is presented here and read at this edge.
        if (probe_stat.none_left) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (func_q == FUNC_INSERT) begin
          ram_we          = 1'b1;
          probe_ctrl.step = 1'b1;
          state_d         = ST_READ;
        end else if (!ram_rdata[bit_sel]) begin
          present_d = 1'b0;
          state_d   = ST_RESP;
        end else begin
          probe_ctrl.step = 1'b1;
          state_d         = ST_READ;
        end
      end
      ST_RESP: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      func_q    <= FUNC_INSERT;
      present_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      func_q    <= func_d;
      present_q <= present_d;
    end
  end

  assign out_valid_o = (state_q == ST_RESP);
  assign present_o   = present_q;

  // Checks on the sequencer.
  `BFDH_ASSERT_IMP(a_no_accept_in_clear, state_q == ST_CLEAR, in_stall_o)
  `BFDH_ASSERT_IMP(a_insert_reports_zero, out_valid_o && (func_q == FUNC_INSERT), !present_o)
  `BFDH_ASSERT_IMP(a_write_only_clear_or_insert, ram_we,
                   (state_q == ST_CLEAR) || ((state_q == ST_CHECK) && (func_q == FUNC_INSERT)))
  `BFDH_ASSERT_NXT(a_accept_starts_probe, in_accept, state_q == ST_READ)

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter testbench
// Drives insert and query items through the double-hashing Bloom filter
// under random idling on both channels. It keeps its own copy of the bit
// table to predict the present flag of every result, and changes the probe
// count between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import bfdh_pkg::*;

  localparam int unsigned CLK_HALF     = 10;
  // Longest item latency at the largest probe count, with some margin.
  localparam int unsigned DRAIN_CYCLES = 2 * 31 + 16;
  localparam int unsigned PHASE_ITEMS  = 88;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [HASH_W-1:0] base;
    logic [HASH_W-1:0] stride;
  } key_t;

  // Shadow of the filter: predicts the present flag of each accepted item.
  class bloom_scoreboard;
    bit [WORD_BITS-1:0] filter_words [TABLE_WORDS];
    logic [CNT_W-1:0]   probes;
    bit                 present_expected [$];
    int unsigned        errors;

    function new();
      probes = PROBE_COUNT_RESET;
      errors = 0;
    endfunction

    function void set_probes(logic [CNT_W-1:0] count);
      probes = count;
    endfunction

    // Walks the probe sequence; an insert sets each bit, a query stops at
    // the first clear bit.
    function void note_item(logic func, key_t key);
      logic [HASH_W-1:0] sum;
      logic [IDX_W-1:0]  idx;
      bit                hit;
      hit = (func == FUNC_QUERY);
      for (int unsigned i = 0; i < probes; i++) begin
        sum = key.base + HASH_W'(i) * key.stride;
        idx = sum[IDX_W-1:0];
        if (func == FUNC_INSERT) begin
          filter_words[idx[IDX_W-1:BIT_W]][idx[BIT_W-1:0]] = 1'b1;
        end else if (!filter_words[idx[IDX_W-1:BIT_W]][idx[BIT_W-1:0]]) begin
          hit = 1'b0;
          break;
        end
      end
      present_expected.push_back(hit);
    endfunction

    function void check_result(logic present);
      bit want;
      if (present_expected.size() == 0) begin
        $display("%0t: result with no item outstanding, expected none, actual %0b",
                 $time, present);
        errors++;
      end else begin
        want = present_expected.pop_front();
        if (present !== want) begin
          $display("%0t: present mismatch, expected %0b, actual %0b", $time, want, present);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return present_expected.size();
    endfunction

    function void close();
      if (present_expected.size() != 0) begin
        $display("%0t: %0d results missing, expected more, actual none",
                 $time, present_expected.size());
        errors += present_expected.size();
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CNT_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              func_i;
  logic [HASH_W-1:0] first_hash_i;
  logic [HASH_W-1:0] second_hash_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              present_o;

  bloom_scoreboard sb;
  bit              quiet;
  bit              hold_done;
  int unsigned     results_seen;
  key_t            inserted_keys [$];

  bloom_filter_double_hash dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .first_hash_i  (first_hash_i),
    .second_hash_i (second_hash_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .present_o     (present_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Offers one item, after an occasional idle burst, and waits until it is taken.
  task automatic send_item(logic func, key_t key);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= func;
    first_hash_i  <= key.base;
    second_hash_i <= key.stride;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Changes the probe count once every outstanding item has completed. The
  // first edge lets the monitor note an item accepted at the previous one.
  task automatic write_probe_count(logic [CNT_W-1:0] count);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_probes(count);
  endtask

  // Accepted input items feed the shadow table.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_item(func_i, key_t'({first_hash_i, second_hash_i}));
    end
  end

  // Accepted results are checked in order.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(present_o);
      results_seen++;
    end
  end

  // Result side: random stall bursts, and one long hold to back the block up.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!hold_done && results_seen >= 150) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  end

  // Stimulus.
  initial begin
    logic [CNT_W-1:0] phase_probes [6];
    key_t             key;
    int unsigned      pick;

    sb            = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    func_i        = FUNC_INSERT;
    first_hash_i  = '0;
    second_hash_i = '0;
    quiet         = 1'b0;
    hold_done     = 1'b0;
    results_seen  = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset probe count: empty table, zero stride,
    // wrapping sums and an even stride.
    send_item(FUNC_QUERY,  key_t'({32'h0000_0000, 32'h0000_0000}));
    send_item(FUNC_INSERT, key_t'({32'h0000_0000, 32'h0000_0000}));
    send_item(FUNC_QUERY,  key_t'({32'h0000_0000, 32'h0000_0000}));
    send_item(FUNC_INSERT, key_t'({32'hFFFF_FFFF, 32'hFFFF_FFFF}));
    send_item(FUNC_QUERY,  key_t'({32'hFFFF_FFFF, 32'hFFFF_FFFF}));
    send_item(FUNC_QUERY,  key_t'({32'hFFFF_FFFF, 32'h0000_0000}));
    send_item(FUNC_INSERT, key_t'({32'h0000_1000, 32'h8000_0000}));
    send_item(FUNC_QUERY,  key_t'({32'h0000_1000, 32'h8000_0000}));
    send_item(FUNC_QUERY,  key_t'({32'h1234_5678, 32'h9ABC_DEF1}));

    // No probes at all: every query reports present, inserts change nothing.
    write_probe_count(5'd0);
    send_item(FUNC_QUERY,  key_t'({32'hA5A5_A5A5, 32'h5A5A_5A5B}));
    send_item(FUNC_INSERT, key_t'({32'hA5A5_A5A5, 32'h5A5A_5A5B}));
    send_item(FUNC_QUERY,  key_t'({32'hCAFE_0001, 32'h0000_0003}));

    // Largest probe count the register holds.
    write_probe_count(5'd31);
    send_item(FUNC_QUERY,  key_t'({32'hA5A5_A5A5, 32'h5A5A_5A5B}));
    send_item(FUNC_INSERT, key_t'({32'hDEAD_BEEF, 32'h1357_9BDF}));
    send_item(FUNC_QUERY,  key_t'({32'hDEAD_BEEF, 32'h1357_9BDF}));
    send_item(FUNC_QUERY,  key_t'({32'hFFFF_FFFF, 32'hFFFF_FFFF}));

    // Single probe: only the base index matters.
    write_probe_count(5'd1);
    send_item(FUNC_QUERY,  key_t'({32'h0000_0000, 32'h7654_3211}));
    send_item(FUNC_QUERY,  key_t'({32'hFFFF_FFFF, 32'h1111_1111}));
    send_item(FUNC_QUERY,  key_t'({32'h0001_0000, 32'h0000_0001}));

    // Random phases over several probe counts; the last runs without idling.
    phase_probes[0] = 5'd16;
    phase_probes[1] = 5'd1;
    phase_probes[2] = 5'd31;
    phase_probes[3] = 5'd0;
    phase_probes[4] = CNT_W'($urandom_range(2, 30));
    phase_probes[5] = PROBE_COUNT_RESET;
    for (int unsigned phase = 0; phase < 6; phase++) begin
      write_probe_count(phase_probes[phase]);
      if (phase == 5) quiet = 1'b1;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55 || inserted_keys.size() == 0) begin
          // Fresh key, stride mostly odd as a caller would make it.
          key.base   = $urandom;
          key.stride = $urandom;
          if ($urandom_range(0, 4) != 0) key.stride[0] = 1'b1;
          inserted_keys.push_back(key);
          send_item(FUNC_INSERT, key);
        end else if (pick < 85) begin
          send_item(FUNC_QUERY, inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
        end else if (pick < 95) begin
          send_item(FUNC_QUERY, key_t'({$urandom, $urandom}));
        end else begin
          // Hashes at their extremes, as either operation.
          key.base   = ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
          key.stride = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom;
          send_item(($urandom_range(0, 1) == 0) ? FUNC_INSERT : FUNC_QUERY, key);
        end
      end
    end

    // Drain and finish.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.close();
    if (sb.errors == 0) begin
      $display("PASS bloom_filter_double_hash");
    end else begin
      $display("FAIL bloom_filter_double_hash");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("FAIL bloom_filter_double_hash");
    $finish;
  end

endmodule
